/* rtl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* rtl/ccs_pkg.sv */
// shared types, widths and codes for the charge cluster statistics block
// no dependencies; used by the controller, datapath, top level and checker
`default_nettype none

package ccs_pkg;

    // field widths
    localparam int unsigned COORD_BITS   = 20;
    localparam int unsigned CHARGE_BITS  = 24;
    localparam int unsigned BASE_W       = 16;
    localparam int unsigned CHARGE_SUM_W = 36;
    localparam int unsigned LENGTH_W     = 34;
    localparam int unsigned PITCH_W      = 32;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned MAX_POINTS   = 4096;

    localparam logic [BASE_W-1:0] BASE_RESET = 16'd3000;

    // stream packing
    localparam int unsigned S_TDATA_W = ((3 * COORD_BITS + CHARGE_BITS + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W = ((CHARGE_SUM_W + LENGTH_W + PITCH_W + 7) / 8) * 8;
    localparam int unsigned X_LSB      = 0;
    localparam int unsigned Y_LSB      = COORD_BITS;
    localparam int unsigned Z_LSB      = 2 * COORD_BITS;
    localparam int unsigned Q_LSB      = 3 * COORD_BITS;
    localparam int unsigned SUM_LSB    = 0;
    localparam int unsigned LEN_LSB    = CHARGE_SUM_W;
    localparam int unsigned PITCH_LSB  = CHARGE_SUM_W + LENGTH_W;

    // arithmetic widths
    localparam int unsigned MUL_A_W  = 2 * BASE_W;
    localparam int unsigned MUL_B_W  = COORD_BITS + 1;
    localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
    localparam int unsigned SSUM_W   = 2 * COORD_BITS + 1;
    localparam int unsigned PT_RAD_W = 2 * COORD_BITS + 2;
    localparam int unsigned RAD_W    = ((MUL_A_W + SSUM_W + 1) / 2) * 2;
    localparam int unsigned ROOT_W   = RAD_W / 2;
    localparam int unsigned REM_W    = ROOT_W + 2;
    localparam int unsigned PT_STEPS    = PT_RAD_W / 2;
    localparam int unsigned PITCH_STEPS = ROOT_W;
    localparam int unsigned DIV_STEPS   = ROOT_W;
    localparam int unsigned CNT_W       = $clog2(ROOT_W);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0]        mag_t;
    typedef logic [CHARGE_BITS-1:0]       charge_t;
    typedef logic [BASE_W-1:0]            base_t;
    typedef logic [CHARGE_SUM_W-1:0]      csum_t;
    typedef logic [LENGTH_W-1:0]          len_t;
    typedef logic [PITCH_W-1:0]           pitch_t;
    typedef logic [MUL_A_W-1:0]           mula_t;
    typedef logic [MUL_B_W-1:0]           mulb_t;
    typedef logic [PROD_W-1:0]            prod_t;
    typedef logic [SSUM_W-1:0]            ssum_t;
    typedef logic [RAD_W-1:0]             rad_t;
    typedef logic [ROOT_W-1:0]            root_t;
    typedef logic [REM_W-1:0]             rem_t;
    typedef logic [CNT_W-1:0]             ccs_cnt_t;
    typedef logic [S_TDATA_W-1:0]         s_tdata_t;
    typedef logic [M_TDATA_W-1:0]         m_tdata_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        PS_OK        = 2'd0,
        PS_NO_TRACK  = 2'd1,
        PS_ZERO_DZ   = 2'd2,
        PS_SATURATED = 2'd3
    } ccs_status_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_SQ,
        ST_RLOAD,
        ST_ROOT,
        ST_ADD_LEN,
        ST_CHECK,
        ST_PITCH,
        ST_DLOAD,
        ST_DIV,
        ST_EMIT
    } ccs_state_t;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MS_DX,
        MS_DY,
        MS_DZ,
        MS_EX,
        MS_EZ,
        MS_BASE,
        MS_SLO,
        MS_SHI
    } ccs_msel_t;

    // accumulator operations
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD,
        ACC_ADD_SH
    } ccs_acc_op_t;

    // controller to datapath
    typedef struct packed {
        logic        in_load;
        logic        acc_point;
        logic        mul_en;
        ccs_msel_t   msel;
        ccs_acc_op_t acc_op;
        logic        bsq_s_load;
        logic        rt_load;
        logic        rt_wide;
        logic        rt_step;
        logic        len_add;
        logic        ext_load;
        logic        dv_load;
        logic        dv_step;
        logic        out_load;
    } ccs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic have_prev;
        logic last;
        logic seen_track;
        logic ez_zero;
    } ccs_stat_t;

endpackage

`default_nettype wire

/* rtl/charge_cluster_statistics.sv */
// top level of the charge cluster statistics block
// depends on ccs_pkg, ccs_ctrl and ccs_dp
//
//   channel   direction  handshake            payload
//   s_        in         s_tvalid / s_tready  s_tdata, s_tuser, s_tlast (one point)
//   m_        out        m_tvalid / m_tready  m_tdata, m_tuser (one cluster result)
//   cfg_      in         cfg_wr_en            cfg_wr_data (base pitch)
//
// after a point that follows another, the input waits through accumulate, square,
// root load, the 21-step integer square root of the squared step and length add;
// after a first point that is not last, only through accumulate; with a track seen
// and a z extent, a last point adds radicand build, 37-step root, 37-step divide
// reset is synchronous, active low; base pitch returns to 3000
// a result waiting in the output register holds the block only when the next
// result is ready to be loaded
`default_nettype none

module charge_cluster_statistics (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [15:0]               cfg_wr_data,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // pos_x, pos_y, pos_z, charge (from bit 0 up)
    input  wire ccs_pkg::s_tdata_t         s_tdata,
    // on_track
    input  wire logic                      s_tuser,
    input  wire logic                      s_tlast,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // charge_sum, path_length, wire_pitch (from bit 0 up)
    output ccs_pkg::m_tdata_t              m_tdata,
    // pitch_status
    output logic [ccs_pkg::STATUS_W-1:0]   m_tuser
);

    ccs_pkg::ccs_cmd_t    cmd;
    ccs_pkg::ccs_stat_t   st;
    ccs_pkg::csum_t       charge_sum;
    ccs_pkg::len_t        path_length;
    ccs_pkg::pitch_t      wire_pitch;
    ccs_pkg::ccs_status_t pitch_status;

    // sequencer
    ccs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .st       (st),
        .cmd      (cmd)
    );

    // arithmetic and cluster state
    ccs_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .pos_x        (s_tdata[ccs_pkg::X_LSB +: ccs_pkg::COORD_BITS]),
        .pos_y        (s_tdata[ccs_pkg::Y_LSB +: ccs_pkg::COORD_BITS]),
        .pos_z        (s_tdata[ccs_pkg::Z_LSB +: ccs_pkg::COORD_BITS]),
        .charge       (s_tdata[ccs_pkg::Q_LSB +: ccs_pkg::CHARGE_BITS]),
        .on_track     (s_tuser),
        .last_point   (s_tlast),
        .cmd          (cmd),
        .st           (st),
        .charge_sum   (charge_sum),
        .path_length  (path_length),
        .wire_pitch   (wire_pitch),
        .pitch_status (pitch_status)
    );

    // result packing
    assign m_tdata = ccs_pkg::m_tdata_t'({wire_pitch, path_length, charge_sum});
    assign m_tuser = pitch_status;

endmodule

`default_nettype wire

/* rtl/ccs_ctrl.sv */
// sequencing state machine for the charge cluster statistics block
// depends on ccs_pkg; drives ccs_dp through the command struct
`default_nettype none

module ccs_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    input  wire ccs_pkg::ccs_stat_t st,
    output ccs_pkg::ccs_cmd_t      cmd
);

    ccs_pkg::ccs_state_t state_reg, state_next;
    ccs_pkg::ccs_cnt_t   cnt_reg, cnt_next;
    logic                pitch_reg, pitch_next;
    logic                m_valid_reg, m_valid_next;

    // state, counter and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ccs_pkg::ST_IDLE;
            cnt_reg     <= '0;
            pitch_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pitch_reg   <= pitch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pitch_next = pitch_reg;
        cmd        = '0;
        cmd.msel   = ccs_pkg::MS_DX;
        cmd.acc_op = ccs_pkg::ACC_HOLD;
        s_tready   = 1'b0;

        case (state_reg)
            ccs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ccs_pkg::ST_ACC;
                end
            end

            ccs_pkg::ST_ACC: begin
                cmd.acc_point = 1'b1;
                cnt_next      = '0;
                if (st.have_prev) begin
                    state_next = ccs_pkg::ST_SQ;
                end else if (st.last) begin
                    state_next = ccs_pkg::ST_CHECK;
                end else begin
                    state_next = ccs_pkg::ST_IDLE;
                end
            end

            // squares of the three step components into the accumulator
            ccs_pkg::ST_SQ: begin
                cnt_next = cnt_reg + ccs_pkg::ccs_cnt_t'(1);
                case (cnt_reg)
                    ccs_pkg::ccs_cnt_t'(0): begin
                        cmd.mul_en = 1'b1;
                        cmd.msel   = ccs_pkg::MS_DX;
                        cmd.acc_op = ccs_pkg::ACC_CLR;
                    end
                    ccs_pkg::ccs_cnt_t'(1): begin
                        cmd.mul_en = 1'b1;
                        cmd.msel   = ccs_pkg::MS_DY;
                        cmd.acc_op = ccs_pkg::ACC_ADD;
                    end
                    ccs_pkg::ccs_cnt_t'(2): begin
                        cmd.mul_en = 1'b1;
                        cmd.msel   = ccs_pkg::MS_DZ;
                        cmd.acc_op = ccs_pkg::ACC_ADD;
                    end
                    default: begin
                        cmd.acc_op = ccs_pkg::ACC_ADD;
                        state_next = ccs_pkg::ST_RLOAD;
                    end
                endcase
            end

            ccs_pkg::ST_RLOAD: begin
                cmd.rt_load = 1'b1;
                cmd.rt_wide = pitch_reg;
                cnt_next    = '0;
                state_next  = ccs_pkg::ST_ROOT;
            end

            // one root bit per cycle
            ccs_pkg::ST_ROOT: begin
                cmd.rt_step = 1'b1;
                cnt_next    = cnt_reg + ccs_pkg::ccs_cnt_t'(1);
                if (pitch_reg) begin
                    if (cnt_reg == ccs_pkg::ccs_cnt_t'(ccs_pkg::PITCH_STEPS - 1)) begin
                        state_next = ccs_pkg::ST_DLOAD;
                    end
                end else begin
                    if (cnt_reg == ccs_pkg::ccs_cnt_t'(ccs_pkg::PT_STEPS - 1)) begin
                        state_next = ccs_pkg::ST_ADD_LEN;
                    end
                end
            end

            ccs_pkg::ST_ADD_LEN: begin
                cmd.len_add = 1'b1;
                state_next  = st.last ? ccs_pkg::ST_CHECK : ccs_pkg::ST_IDLE;
            end

            ccs_pkg::ST_CHECK: begin
                cmd.ext_load = 1'b1;
                cnt_next     = '0;
                if (!st.seen_track || st.ez_zero) begin
                    state_next = ccs_pkg::ST_EMIT;
                end else begin
                    pitch_next = 1'b1;
                    state_next = ccs_pkg::ST_PITCH;
                end
            end

            // radicand base^2 * (ex^2 + ez^2) from partial products
            ccs_pkg::ST_PITCH: begin
                cnt_next = cnt_reg + ccs_pkg::ccs_cnt_t'(1);
                case (cnt_reg)
                    ccs_pkg::ccs_cnt_t'(0): begin
                        cmd.mul_en = 1'b1;
                        cmd.msel   = ccs_pkg::MS_EX;
                        cmd.acc_op = ccs_pkg::ACC_CLR;
                    end
                    ccs_pkg::ccs_cnt_t'(1): begin
                        cmd.mul_en = 1'b1;
                        cmd.msel   = ccs_pkg::MS_EZ;
                        cmd.acc_op = ccs_pkg::ACC_ADD;
                    end
                    ccs_pkg::ccs_cnt_t'(2): begin
                        cmd.mul_en = 1'b1;
                        cmd.msel   = ccs_pkg::MS_BASE;
                        cmd.acc_op = ccs_pkg::ACC_ADD;
                    end
                    ccs_pkg::ccs_cnt_t'(3): begin
                        cmd.bsq_s_load = 1'b1;
                        cmd.acc_op     = ccs_pkg::ACC_CLR;
                    end
                    ccs_pkg::ccs_cnt_t'(4): begin
                        cmd.mul_en = 1'b1;
                        cmd.msel   = ccs_pkg::MS_SLO;
                    end
                    ccs_pkg::ccs_cnt_t'(5): begin
                        cmd.mul_en = 1'b1;
                        cmd.msel   = ccs_pkg::MS_SHI;
                        cmd.acc_op = ccs_pkg::ACC_ADD;
                    end
                    default: begin
                        cmd.acc_op = ccs_pkg::ACC_ADD_SH;
                        state_next = ccs_pkg::ST_RLOAD;
                    end
                endcase
            end

            ccs_pkg::ST_DLOAD: begin
                cmd.dv_load = 1'b1;
                cnt_next    = '0;
                state_next  = ccs_pkg::ST_DIV;
            end

            // one quotient bit per cycle
            ccs_pkg::ST_DIV: begin
                cmd.dv_step = 1'b1;
                cnt_next    = cnt_reg + ccs_pkg::ccs_cnt_t'(1);
                if (cnt_reg == ccs_pkg::ccs_cnt_t'(ccs_pkg::DIV_STEPS - 1)) begin
                    state_next = ccs_pkg::ST_EMIT;
                end
            end

            // hand the result to the output register once it is free
            ccs_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    pitch_next   = 1'b0;
                    state_next   = ccs_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ccs_pkg::ST_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when the transaction completes
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

/* rtl/ccs_dp.sv */
// datapath: running sums, extents, shared multiplier, root and divide steps
// depends on ccs_pkg; commanded by ccs_ctrl
`default_nettype none

module ccs_dp (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire ccs_pkg::base_t       cfg_wr_data,
    input  wire ccs_pkg::coord_t      pos_x,
    input  wire ccs_pkg::coord_t      pos_y,
    input  wire ccs_pkg::coord_t      pos_z,
    input  wire ccs_pkg::charge_t     charge,
    input  wire logic                 on_track,
    input  wire logic                 last_point,
    input  wire ccs_pkg::ccs_cmd_t    cmd,
    output ccs_pkg::ccs_stat_t        st,
    output ccs_pkg::csum_t            charge_sum,
    output ccs_pkg::len_t             path_length,
    output ccs_pkg::pitch_t           wire_pitch,
    output ccs_pkg::ccs_status_t      pitch_status
);

    // magnitude of the difference of two coordinates
    function automatic ccs_pkg::mag_t abs_diff(input ccs_pkg::coord_t a,
                                               input ccs_pkg::coord_t b);
        logic signed [ccs_pkg::COORD_BITS:0] d;
        d = {a[ccs_pkg::COORD_BITS-1], a} - {b[ccs_pkg::COORD_BITS-1], b};
        if (d[ccs_pkg::COORD_BITS]) begin
            d = -d;
        end
        return d[ccs_pkg::COORD_BITS-1:0];
    endfunction

    ccs_pkg::base_t   base_pitch_reg;
    ccs_pkg::coord_t  in_x_reg, in_y_reg, in_z_reg;
    ccs_pkg::charge_t in_q_reg;
    logic             in_trk_reg, in_last_reg;
    ccs_pkg::coord_t  prev_x_reg, prev_y_reg, prev_z_reg;
    logic             have_prev_reg, seen_track_reg;
    ccs_pkg::csum_t   charge_total_reg, charge_total_next;
    ccs_pkg::len_t    length_total_reg, length_total_next;
    ccs_pkg::coord_t  min_x_reg, max_x_reg, min_z_reg, max_z_reg;
    ccs_pkg::mag_t    dx_reg, dy_reg, dz_reg, ex_reg, ez_reg;
    ccs_pkg::mula_t   mul_a, bsq_reg;
    ccs_pkg::mulb_t   mul_b;
    ccs_pkg::prod_t   prod_reg;
    ccs_pkg::rad_t    acc_reg, acc_next;
    ccs_pkg::ssum_t   s_reg;
    ccs_pkg::rad_t    rad_reg;
    ccs_pkg::rem_t    rem_reg, rem_sh, trial;
    ccs_pkg::root_t   root_reg;
    logic             rt_ge;
    ccs_pkg::mag_t    dv_rem_reg;
    ccs_pkg::root_t   dv_quo_reg;
    logic [ccs_pkg::COORD_BITS:0] dv_t, dv_diff;
    logic             dv_ge;
    ccs_pkg::csum_t   out_sum_reg;
    ccs_pkg::len_t    out_len_reg;
    ccs_pkg::pitch_t  out_pitch_reg;
    ccs_pkg::ccs_status_t out_status_reg, status_next;

    logic [ccs_pkg::CHARGE_SUM_W:0] csum_wide;
    logic [ccs_pkg::LENGTH_W:0]     lsum_wide;

    // saturating charge and length sums
    always_comb begin
        csum_wide = {1'b0, charge_total_reg}
                  + {{(ccs_pkg::CHARGE_SUM_W + 1 - ccs_pkg::CHARGE_BITS){1'b0}}, in_q_reg};
        charge_total_next = csum_wide[ccs_pkg::CHARGE_SUM_W] ? '1
                          : csum_wide[ccs_pkg::CHARGE_SUM_W-1:0];
        lsum_wide = {1'b0, length_total_reg}
                  + {{(ccs_pkg::LENGTH_W + 1 - ccs_pkg::PT_STEPS){1'b0}},
                     root_reg[ccs_pkg::PT_STEPS-1:0]};
        length_total_next = lsum_wide[ccs_pkg::LENGTH_W] ? '1
                          : lsum_wide[ccs_pkg::LENGTH_W-1:0];
    end

    // configuration and cluster control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_pitch_reg   <= ccs_pkg::BASE_RESET;
            have_prev_reg    <= 1'b0;
            seen_track_reg   <= 1'b0;
            charge_total_reg <= '0;
            length_total_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                base_pitch_reg <= cfg_wr_data;
            end
            if (cmd.out_load) begin
                have_prev_reg    <= 1'b0;
                seen_track_reg   <= 1'b0;
                charge_total_reg <= '0;
                length_total_reg <= '0;
            end else begin
                if (cmd.acc_point) begin
                    have_prev_reg    <= 1'b1;
                    charge_total_reg <= charge_total_next;
                    if (in_trk_reg) begin
                        seen_track_reg <= 1'b1;
                    end
                end
                if (cmd.len_add) begin
                    length_total_reg <= length_total_next;
                end
            end
        end
    end

    // point capture, previous point, step components and extents
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            in_x_reg    <= pos_x;
            in_y_reg    <= pos_y;
            in_z_reg    <= pos_z;
            in_q_reg    <= charge;
            in_trk_reg  <= on_track;
            in_last_reg <= last_point;
        end
        if (cmd.acc_point) begin
            dx_reg     <= abs_diff(in_x_reg, prev_x_reg);
            dy_reg     <= abs_diff(in_y_reg, prev_y_reg);
            dz_reg     <= abs_diff(in_z_reg, prev_z_reg);
            prev_x_reg <= in_x_reg;
            prev_y_reg <= in_y_reg;
            prev_z_reg <= in_z_reg;
            if (in_trk_reg) begin
                if (!seen_track_reg || in_x_reg < min_x_reg) min_x_reg <= in_x_reg;
                if (!seen_track_reg || in_x_reg > max_x_reg) max_x_reg <= in_x_reg;
                if (!seen_track_reg || in_z_reg < min_z_reg) min_z_reg <= in_z_reg;
                if (!seen_track_reg || in_z_reg > max_z_reg) max_z_reg <= in_z_reg;
            end
        end
        if (cmd.ext_load) begin
            ex_reg <= ccs_pkg::mag_t'(max_x_reg - min_x_reg);
            ez_reg <= ccs_pkg::mag_t'(max_z_reg - min_z_reg);
        end
    end

    // shared multiplier operand selection
    always_comb begin
        case (cmd.msel)
            ccs_pkg::MS_DX: begin
                mul_a = ccs_pkg::mula_t'(dx_reg);
                mul_b = ccs_pkg::mulb_t'(dx_reg);
            end
            ccs_pkg::MS_DY: begin
                mul_a = ccs_pkg::mula_t'(dy_reg);
                mul_b = ccs_pkg::mulb_t'(dy_reg);
            end
            ccs_pkg::MS_DZ: begin
                mul_a = ccs_pkg::mula_t'(dz_reg);
                mul_b = ccs_pkg::mulb_t'(dz_reg);
            end
            ccs_pkg::MS_EX: begin
                mul_a = ccs_pkg::mula_t'(ex_reg);
                mul_b = ccs_pkg::mulb_t'(ex_reg);
            end
            ccs_pkg::MS_EZ: begin
                mul_a = ccs_pkg::mula_t'(ez_reg);
                mul_b = ccs_pkg::mulb_t'(ez_reg);
            end
            ccs_pkg::MS_BASE: begin
                mul_a = ccs_pkg::mula_t'(base_pitch_reg);
                mul_b = ccs_pkg::mulb_t'(base_pitch_reg);
            end
            ccs_pkg::MS_SLO: begin
                mul_a = bsq_reg;
                mul_b = s_reg[ccs_pkg::MUL_B_W-1:0];
            end
            ccs_pkg::MS_SHI: begin
                mul_a = bsq_reg;
                mul_b = ccs_pkg::mulb_t'(s_reg[ccs_pkg::SSUM_W-1:ccs_pkg::MUL_B_W]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // accumulator
    always_comb begin
        case (cmd.acc_op)
            ccs_pkg::ACC_CLR:    acc_next = '0;
            ccs_pkg::ACC_ADD:    acc_next = acc_reg + ccs_pkg::rad_t'(prod_reg);
            ccs_pkg::ACC_ADD_SH: acc_next = acc_reg
                                          + (ccs_pkg::rad_t'(prod_reg) << ccs_pkg::MUL_B_W);
            default:             acc_next = acc_reg;
        endcase
    end

    // root step: two radicand bits in, one root bit out
    always_comb begin
        rem_sh = {rem_reg[ccs_pkg::REM_W-3:0], rad_reg[ccs_pkg::RAD_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        rt_ge  = (rem_sh >= trial);
    end

    // divide step: one quotient bit out
    always_comb begin
        dv_t    = {dv_rem_reg, dv_quo_reg[ccs_pkg::ROOT_W-1]};
        dv_diff = dv_t - {1'b0, ez_reg};
        dv_ge   = (dv_t >= {1'b0, ez_reg});
    end

    // multiplier, accumulator, root and divide registers
    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        acc_reg <= acc_next;
        if (cmd.bsq_s_load) begin
            bsq_reg <= prod_reg[ccs_pkg::MUL_A_W-1:0];
            s_reg   <= acc_reg[ccs_pkg::SSUM_W-1:0];
        end
        if (cmd.rt_load) begin
            rad_reg  <= cmd.rt_wide ? acc_reg
                                    : (acc_reg << (ccs_pkg::RAD_W - ccs_pkg::PT_RAD_W));
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.rt_step) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rt_ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ccs_pkg::ROOT_W-2:0], rt_ge};
        end
        if (cmd.dv_load) begin
            dv_rem_reg <= '0;
            dv_quo_reg <= root_reg;
        end else if (cmd.dv_step) begin
            dv_rem_reg <= dv_ge ? dv_diff[ccs_pkg::COORD_BITS-1:0]
                                : dv_t[ccs_pkg::COORD_BITS-1:0];
            dv_quo_reg <= {dv_quo_reg[ccs_pkg::ROOT_W-2:0], dv_ge};
        end
    end

    // result status
    always_comb begin
        if (!seen_track_reg) begin
            status_next = ccs_pkg::PS_NO_TRACK;
        end else if (st.ez_zero) begin
            status_next = ccs_pkg::PS_ZERO_DZ;
        end else if (|dv_quo_reg[ccs_pkg::ROOT_W-1:ccs_pkg::PITCH_W]) begin
            status_next = ccs_pkg::PS_SATURATED;
        end else begin
            status_next = ccs_pkg::PS_OK;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_sum_reg    <= charge_total_reg;
            out_len_reg    <= length_total_reg;
            out_pitch_reg  <= (status_next == ccs_pkg::PS_OK)
                            ? dv_quo_reg[ccs_pkg::PITCH_W-1:0] : '0;
            out_status_reg <= status_next;
        end
    end

    assign st.have_prev  = have_prev_reg;
    assign st.last       = in_last_reg;
    assign st.seen_track = seen_track_reg;
    assign st.ez_zero    = (max_z_reg == min_z_reg);

    assign charge_sum   = out_sum_reg;
    assign path_length  = out_len_reg;
    assign wire_pitch   = out_pitch_reg;
    assign pitch_status = out_status_reg;

endmodule

`default_nettype wire

/* rtl/ccs_checker.sv */
// port-level checks for the charge cluster statistics block, bound to the top level
// depends on ccs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ccs_checker (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire ccs_pkg::m_tdata_t       m_tdata,
    input  wire logic [ccs_pkg::STATUS_W-1:0] m_tuser
);

    logic [ccs_pkg::M_TDATA_W+ccs_pkg::STATUS_W-1:0] m_payload;
    ccs_pkg::pitch_t                                 m_pitch;

    // result fields seen on the ports
    assign m_payload = {m_tuser, m_tdata};
    assign m_pitch   = m_tdata[ccs_pkg::PITCH_LSB +: ccs_pkg::PITCH_W];

    // a stalled result transaction keeps its payload
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_payload))

    // any non-ok status carries a zero pitch
    `ASSERT_IMP(a_pitch_zero, aclk, aresetn, m_tvalid && (m_tuser != ccs_pkg::PS_OK), m_pitch == '0)

    // one point at a time: an accepted transaction makes the input busy
    `ASSERT_NXT(a_one_point, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a new result is only produced while the input side is busy
    `ASSERT_IMP(a_emit_busy, aclk, aresetn, $rose(m_tvalid), $past(!s_tready))

endmodule

bind charge_cluster_statistics ccs_checker u_ccs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
